// File: design/sorted_pair_table_lookup_top_assert.svh
// Assertion macros for the sorted pair table lookup block.
// Expects clk and rst_n to be visible where the macros are used.
`ifndef SORTED_PAIR_TABLE_LOOKUP_TOP_ASSERT_SVH
`define SORTED_PAIR_TABLE_LOOKUP_TOP_ASSERT_SVH

// Checked only while the block is out of reset.
`define SPTL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, including the ones that sample reset.
`define SPTL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/sptl_pkg.sv
// Shared widths, payload types and request codes of the sorted pair table lookup.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package sptl_pkg;

  localparam int unsigned OPC_W       = 2;
  localparam int unsigned ENTRY_IDX_W = 10;
  localparam int unsigned KEY_W       = 21;
  localparam int unsigned CODE_W      = 32;
  localparam int unsigned CNT_CFG_W   = 11;

  typedef logic [OPC_W-1:0]       opcode_t;
  typedef logic [ENTRY_IDX_W-1:0] entry_idx_t;
  typedef logic [KEY_W-1:0]       key_t;
  typedef logic [CODE_W-1:0]      code_t;
  typedef logic [CNT_CFG_W-1:0]   count_cfg_t;

  // Request codes. The fourth code has no meaning and is dropped.
  localparam opcode_t OPC_LOAD = 2'd0;
  localparam opcode_t OPC_FWD  = 2'd1;
  localparam opcode_t OPC_REV  = 2'd2;

endpackage

`default_nettype wire

// File: design/sptl_ifs.sv
// Channel interfaces of the sorted pair table lookup: request, response, configuration.
// Depends on sptl_pkg for the payload types.
`default_nettype none

interface sptl_req_if;
  import sptl_pkg::*;
  logic       valid;
  logic       ready;
  opcode_t    opcode;
  entry_idx_t entry_index;
  key_t       key_value;
  code_t      mapped_code;
  modport source (output valid, output opcode, output entry_index, output key_value,
                  output mapped_code, input ready);
  modport sink   (input valid, input opcode, input entry_index, input key_value,
                  input mapped_code, output ready);
  modport mon    (input valid, input ready, input opcode, input entry_index,
                  input key_value, input mapped_code);
endinterface

interface sptl_rsp_if;
  import sptl_pkg::*;
  logic  valid;
  logic  ready;
  code_t answer_value;
  logic  found;
  modport source (output valid, output answer_value, output found, input ready);
  modport sink   (input valid, input answer_value, input found, output ready);
  modport mon    (input valid, input ready, input answer_value, input found);
endinterface

interface sptl_cfg_if;
  import sptl_pkg::*;
  logic       valid;
  logic       ready;
  count_cfg_t entries_in_use;
  modport source (output valid, output entries_in_use, input ready);
  modport sink   (input valid, input entries_in_use, output ready);
  modport mon    (input valid, input ready, input entries_in_use);
endinterface

`default_nettype wire

// File: design/sorted_pair_table_lookup_top.sv
// Top level of the sorted pair table lookup: key and code memories plus search sequencer.
// Depends on sptl_pkg and the channel interfaces in sptl_ifs.sv.
`default_nettype none

// The block keeps TABLE_DEPTH key/code pairs in two synchronous memories with one write
// port and one read port each and serves one request at a time. A load request produces
// no response. A forward lookup binary-searches the keys of the first entries_in_use
// entries; each probe issues the address, then compares on the registered read data.
// A reverse lookup streams one memory read per cycle from index 0 upward and stops at
// the first matching code. Both lookups share the single read port of the memories.
// A finished response sits in an output register, so the next request is accepted
// while the response waits to be taken. Configuration writes are always accepted and
// must only be issued while no request is in flight. Table entries come out of reset
// undefined and must be loaded before any lookup can reach them.
module sorted_pair_table_lookup_top #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  sptl_req_if.sink    in_ch,
  sptl_rsp_if.source  out_ch,
  sptl_cfg_if.sink    cfg_ch
);
  import sptl_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [31:0] DEPTH_32 = 32'(TABLE_DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_FWD_ISSUE = 5'b00010,
    ST_FWD_CMP   = 5'b00100,
    ST_REV_SCAN  = 5'b01000,
    ST_DONE      = 5'b10000
  } state_t;

  // Table storage. No reset: entries are only meaningful once loaded.
  key_t  key_mem  [TABLE_DEPTH];
  code_t code_mem [TABLE_DEPTH];
  key_t  key_rd_r;
  code_t code_rd_r;

  state_t           state_r, state_nxt;
  count_cfg_t       count_r, count_nxt;
  logic [CNT_W-1:0] eff_cnt;
  logic [31:0]      cnt_ext;

  // Forward search window is [lo, end), so hi is end - 1.
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] end_r, end_nxt;
  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid_full;

  // Reverse scan issue pointer and valid flag of the read in flight.
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             rd_vld_r, rd_vld_nxt;

  key_t  key_q_r, key_q_nxt;
  code_t code_q_r, code_q_nxt;
  code_t ans_r, ans_nxt;
  logic  hit_r, hit_nxt;

  logic  out_valid_r, out_valid_nxt;
  code_t out_answer_r, out_answer_nxt;
  logic  out_found_r, out_found_nxt;

  logic             in_acc;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.answer_value = out_answer_r;
  assign out_ch.found        = out_found_r;

  // A count beyond the table depth is clamped to the depth.
  assign cnt_ext = 32'(count_r);
  assign eff_cnt = (cnt_ext > DEPTH_32) ? CNT_W'(DEPTH_32) : CNT_W'(cnt_ext);

  // mid = floor((lo + hi) / 2); only used while lo < end, so the sum never underflows.
  assign mid_sum  = {1'b0, lo_r} + {1'b0, end_r} - (CNT_W + 1)'(1);
  assign mid_full = mid_sum[CNT_W:1];

  // The reverse scan owns the read port in its state; otherwise the probe address does.
  assign rd_addr = (state_r == ST_REV_SCAN) ? idx_r[IDX_W-1:0] : mid_full[IDX_W-1:0];

  // Loads write straight from the request; slots past the table depth are dropped.
  assign wr_en   = in_acc && (in_ch.opcode == OPC_LOAD) &&
                   (32'(in_ch.entry_index) < DEPTH_32);
  assign wr_addr = IDX_W'(in_ch.entry_index);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]  <= in_ch.key_value;
      code_mem[wr_addr] <= in_ch.mapped_code;
    end
    key_rd_r  <= key_mem[rd_addr];
    code_rd_r <= code_mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    lo_nxt         = lo_r;
    end_nxt        = end_r;
    idx_nxt        = idx_r;
    rd_vld_nxt     = 1'b0;
    key_q_nxt      = key_q_r;
    code_q_nxt     = code_q_r;
    ans_nxt        = ans_r;
    hit_nxt        = hit_r;
    out_valid_nxt  = out_valid_r;
    out_answer_nxt = out_answer_r;
    out_found_nxt  = out_found_r;

    if (cfg_ch.valid && cfg_ch.ready) begin
      count_nxt = cfg_ch.entries_in_use;
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.opcode)
            OPC_FWD: begin
              key_q_nxt = in_ch.key_value;
              lo_nxt    = '0;
              end_nxt   = eff_cnt;
              state_nxt = ST_FWD_ISSUE;
            end
            OPC_REV: begin
              code_q_nxt = in_ch.mapped_code;
              idx_nxt    = '0;
              state_nxt  = ST_REV_SCAN;
            end
            default: begin
              // Loads are written above; the unused code is dropped.
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_FWD_ISSUE: begin
        // The probe read at mid is launched on this edge when the window is open.
        if (lo_r < end_r) begin
          state_nxt = ST_FWD_CMP;
        end else begin
          ans_nxt   = '0;
          hit_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end
      end

      ST_FWD_CMP: begin
        if (key_rd_r == key_q_r) begin
          ans_nxt   = code_rd_r;
          hit_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else if (key_rd_r < key_q_r) begin
          lo_nxt    = mid_full + CNT_W'(1);
          state_nxt = ST_FWD_ISSUE;
        end else begin
          end_nxt   = mid_full;
          state_nxt = ST_FWD_ISSUE;
        end
      end

      ST_REV_SCAN: begin
        // Reads run one ahead of the compare; reads past a hit are simply discarded.
        if (rd_vld_r && (code_rd_r == code_q_r)) begin
          ans_nxt   = CODE_W'(key_rd_r);
          hit_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else if (idx_r < eff_cnt) begin
          idx_nxt    = idx_r + CNT_W'(1);
          rd_vld_nxt = 1'b1;
        end else begin
          ans_nxt   = '0;
          hit_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        // Hand the response to the output register once it is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_answer_nxt = ans_r;
          out_found_nxt  = hit_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    end_r        <= end_nxt;
    idx_r        <= idx_nxt;
    key_q_r      <= key_q_nxt;
    code_q_r     <= code_q_nxt;
    ans_r        <= ans_nxt;
    hit_r        <= hit_nxt;
    out_answer_r <= out_answer_nxt;
    out_found_r  <= out_found_nxt;
  end

endmodule

`default_nettype wire

// File: design/sptl_checker.sv
// Port-level checks of the sorted pair table lookup, bound to its top level.
// Depends on sptl_pkg and the assertion macro header.
`default_nettype none

`include "sorted_pair_table_lookup_top_assert.svh"

module sptl_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input sptl_pkg::opcode_t in_opcode,
  input logic              out_valid,
  input logic              out_ready,
  input sptl_pkg::code_t   out_answer,
  input logic              out_found
);
  import sptl_pkg::*;

  logic            in_acc;
  logic            lookup_op;
  logic            lookup_acc;
  logic            other_acc;
  logic            out_stall;
  logic            out_miss;
  logic [CODE_W:0] out_data;

  assign in_acc     = in_valid && in_ready;
  assign lookup_op  = (in_opcode == OPC_FWD) || (in_opcode == OPC_REV);
  assign lookup_acc = in_acc && lookup_op;
  assign other_acc  = in_acc && !lookup_op;
  assign out_stall  = out_valid && !out_ready;
  assign out_miss   = out_valid && !out_found;
  assign out_data   = {out_answer, out_found};

  `SPTL_ASSERT_ALWAYS(a_reset_clean, !rst_n |=> (!out_valid && in_ready), "not idle after reset")

  `SPTL_ASSERT(a_rsp_hold, out_stall |=> (out_valid && $stable(out_data)), "response not held")

  `SPTL_ASSERT(a_lookup_busy, lookup_acc |=> !in_ready, "lookup did not hold the block")

  `SPTL_ASSERT(a_load_free, other_acc |=> in_ready, "load or dropped request stalled the block")

  `SPTL_ASSERT(a_miss_zero, out_miss |-> (out_answer == '0), "miss carries a nonzero answer")

endmodule

bind sorted_pair_table_lookup_top sptl_checker u_sptl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_opcode  (in_ch.opcode),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_answer (out_ch.answer_value),
  .out_found  (out_ch.found)
);

`default_nettype wire
